// ===== hdl/clfsm_pkg.sv =====
package clfsm_pkg;

    // operation codes carried in tuser
    localparam logic [1:0] OP_SEND  = 2'd0;
    localparam logic [1:0] OP_RECV  = 2'd1;
    localparam logic [1:0] OP_CLOSE = 2'd2;
    localparam logic [1:0] OP_TAKE  = 2'd3;

    // commands
    localparam logic [2:0] C_HELO     = 3'd0;
    localparam logic [2:0] C_SYN      = 3'd1;
    localparam logic [2:0] C_SYN_ACK  = 3'd2;
    localparam logic [2:0] C_DATA     = 3'd3;
    localparam logic [2:0] C_DATA_ACK = 3'd4;
    localparam logic [2:0] C_CLOSE    = 3'd5;

    // life-cycle states
    localparam logic [2:0] ST_CLOSED      = 3'd0;
    localparam logic [2:0] ST_LISTEN      = 3'd1;
    localparam logic [2:0] ST_SYN_RCVD    = 3'd2;
    localparam logic [2:0] ST_SYN_SENT    = 3'd3;
    localparam logic [2:0] ST_ESTABLISHED = 3'd4;
    localparam logic [2:0] ST_CLOSE_WAIT  = 3'd5;

    // reply codes
    localparam logic [2:0] R_NONE      = 3'd0;
    localparam logic [2:0] R_SYN       = 3'd1;
    localparam logic [2:0] R_SYN_ACK   = 3'd2;
    localparam logic [2:0] R_DATA_ACK  = 3'd3;
    localparam logic [2:0] R_CLOSE_ACK = 3'd4;

    // sequence base loaded on syn
    localparam logic [15:0] SYN_SEQ_BASE = 16'h0100;

    // result word, accepted in the lowest bit
    typedef struct packed {
        logic [15:0] remote_seq_out;
        logic [15:0] local_seq_out;
        logic [2:0]  reply_code;
        logic [2:0]  life_state;
        logic        accepted;
    } t_result;

endpackage

// ===== hdl/connection_lifecycle_fsm_core.sv =====
// Connection life-cycle state machine with a three-way-handshake flavor. Each
// input word carries an operation in tuser (send, receive, force close, take
// local sequence) and a command plus peer sequence in tdata; exactly one result
// word comes back per input word, holding the accepted flag, the new state, a
// reply code and both sequence numbers. One word is accepted every clock cycle
// unless the output stalls; its result appears in the output register on the
// next cycle. The state and sequence registers update in the same edge that
// accepts the word, and the single output register takes a new word whenever it
// is empty or being drained, so throughput is one word per unstalled cycle.
module connection_lifecycle_fsm_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [23:0] i_s_axis_tdata,  // cmd[2:0], peer_sequence[18:3], zero pad
    input  logic [1:0]  i_s_axis_tuser,  // op[1:0]
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [39:0] o_m_axis_tdata   // accepted[0], life_state[3:1],
                                         // reply_code[6:4], local_seq_out[22:7],
                                         // remote_seq_out[38:23], zero pad
);

    logic [2:0]  r_life_state, n_life_state;
    logic [15:0] r_local_seq, n_local_seq;
    logic [15:0] r_remote_seq, n_remote_seq;
    logic        r_out_valid;
    clfsm_pkg::t_result r_result, n_result;

    logic        w_accept;
    logic [1:0]  w_op;
    logic [2:0]  w_cmd;
    logic [15:0] w_peer;
    logic        w_ok;
    logic [2:0]  w_reply;

    assign w_op   = i_s_axis_tuser;
    assign w_cmd  = i_s_axis_tdata[2:0];
    assign w_peer = i_s_axis_tdata[18:3];

    // output register frees up when empty or drained this cycle
    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;

    // next-state and reply logic
    always_comb begin
        n_life_state = r_life_state;
        n_local_seq  = r_local_seq;
        n_remote_seq = r_remote_seq;
        w_ok         = 1'b0;
        w_reply      = clfsm_pkg::R_NONE;
        case (w_op)
            clfsm_pkg::OP_SEND: begin
                if (w_cmd == clfsm_pkg::C_SYN) begin
                    n_local_seq = clfsm_pkg::SYN_SEQ_BASE;
                end
                if (r_life_state == clfsm_pkg::ST_CLOSED && w_cmd == clfsm_pkg::C_HELO) begin
                    n_life_state = clfsm_pkg::ST_LISTEN;
                    w_ok         = 1'b1;
                end else if (r_life_state == clfsm_pkg::ST_LISTEN
                             && w_cmd == clfsm_pkg::C_SYN) begin
                    n_life_state = clfsm_pkg::ST_SYN_SENT;
                    w_ok         = 1'b1;
                end else if (r_life_state == clfsm_pkg::ST_SYN_RCVD
                             && w_cmd == clfsm_pkg::C_SYN_ACK) begin
                    n_life_state = clfsm_pkg::ST_ESTABLISHED;
                    w_ok         = 1'b1;
                end else if (r_life_state == clfsm_pkg::ST_ESTABLISHED
                             && w_cmd == clfsm_pkg::C_CLOSE) begin
                    n_life_state = clfsm_pkg::ST_CLOSE_WAIT;
                    w_ok         = 1'b1;
                end
            end
            clfsm_pkg::OP_RECV: begin
                // other commands are ignored entirely
                if (w_cmd inside {[clfsm_pkg::C_HELO:clfsm_pkg::C_CLOSE]}) begin
                    if (r_life_state == clfsm_pkg::ST_CLOSED
                        && w_cmd == clfsm_pkg::C_HELO) begin
                        n_life_state = clfsm_pkg::ST_LISTEN;
                        w_reply      = clfsm_pkg::R_SYN;
                        w_ok         = 1'b1;
                    end else if (r_life_state == clfsm_pkg::ST_LISTEN
                                 && w_cmd == clfsm_pkg::C_SYN) begin
                        n_life_state = clfsm_pkg::ST_SYN_RCVD;
                        w_reply      = clfsm_pkg::R_SYN_ACK;
                        w_ok         = 1'b1;
                    end else if ((r_life_state == clfsm_pkg::ST_SYN_SENT
                                  || r_life_state == clfsm_pkg::ST_SYN_RCVD)
                                 && w_cmd == clfsm_pkg::C_SYN_ACK) begin
                        n_life_state = clfsm_pkg::ST_ESTABLISHED;
                        w_ok         = 1'b1;
                    end else if (r_life_state == clfsm_pkg::ST_SYN_RCVD) begin
                        w_reply = clfsm_pkg::R_SYN_ACK;
                    end else if (r_life_state == clfsm_pkg::ST_ESTABLISHED
                                 && w_cmd == clfsm_pkg::C_DATA) begin
                        w_reply = clfsm_pkg::R_DATA_ACK;
                    end else if (r_life_state == clfsm_pkg::ST_ESTABLISHED
                                 && w_cmd == clfsm_pkg::C_CLOSE) begin
                        n_life_state = clfsm_pkg::ST_CLOSED;
                        w_reply      = clfsm_pkg::R_CLOSE_ACK;
                        w_ok         = 1'b1;
                    end else if (r_life_state == clfsm_pkg::ST_CLOSE_WAIT
                                 && w_cmd == clfsm_pkg::C_CLOSE) begin
                        n_life_state = clfsm_pkg::ST_CLOSED;
                        w_ok         = 1'b1;
                    end
                    // a received syn loads both sequence numbers
                    if (w_cmd == clfsm_pkg::C_SYN) begin
                        n_remote_seq = w_peer;
                        n_local_seq  = w_peer + clfsm_pkg::SYN_SEQ_BASE;
                    end
                end
            end
            clfsm_pkg::OP_CLOSE: begin
                n_life_state = clfsm_pkg::ST_CLOSED;
            end
            clfsm_pkg::OP_TAKE: begin
                n_local_seq = r_local_seq + 16'd1;
            end
            default: begin
                n_life_state = r_life_state;
            end
        endcase
    end

    // result word
    always_comb begin
        n_result.accepted       = w_ok;
        n_result.life_state     = n_life_state;
        n_result.reply_code     = w_reply;
        n_result.local_seq_out  = (w_op == clfsm_pkg::OP_TAKE) ? r_local_seq : n_local_seq;
        n_result.remote_seq_out = n_remote_seq;
    end

    // connection state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_life_state <= clfsm_pkg::ST_CLOSED;
            r_local_seq  <= 16'd0;
            r_remote_seq <= 16'd0;
        end else if (w_accept) begin
            r_life_state <= n_life_state;
            r_local_seq  <= n_local_seq;
            r_remote_seq <= n_remote_seq;
        end
    end

    // output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_result <= n_result;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {1'b0, r_result};

    // force close always lands in closed
    a_force_close: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_op == clfsm_pkg::OP_CLOSE) |=> r_life_state == clfsm_pkg::ST_CLOSED)
        else $error("force close did not reach closed");

    // sequence take bumps local sequence by one
    a_take_incr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_op == clfsm_pkg::OP_TAKE)
        |=> r_local_seq == 16'($past(r_local_seq) + 16'd1))
        else $error("local sequence not incremented on take");

    // result reflects the registered state of the word just taken
    a_result_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_result.life_state == r_life_state
                      && r_result.remote_seq_out == r_remote_seq))
        else $error("result word disagrees with state registers");

    // a syn reply only comes with the move into listen
    a_syn_reply: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_result.reply_code == clfsm_pkg::R_SYN)
        |-> (r_result.accepted && r_result.life_state == clfsm_pkg::ST_LISTEN))
        else $error("syn reply without transition to listen");

endmodule

// ===== bench/tb_top.sv =====
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    // commands outside the handshake set
    localparam logic [2:0] C_OTHER_LO = 3'd6;
    localparam logic [2:0] C_OTHER_HI = 3'd7;

    localparam int NUM_DIRECTED   = 25;
    localparam int NUM_RANDOM     = 1800;
    localparam int TOTAL_WORDS    = NUM_DIRECTED + NUM_RANDOM;
    localparam int DRAIN_CYCLES   = 8;
    localparam int WATCHDOG_LIMIT = 2000;

    typedef struct {
        logic [1:0]         op;
        logic [2:0]         cmd;
        logic [15:0]        peer;
        bit                 typed;
        clfsm_pkg::t_result want;
    } t_row;

    logic        i_clk;
    logic        i_rst_n         = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [23:0] i_s_axis_tdata  = '0;  // cmd[2:0], peer_sequence[18:3], zero pad
    logic [1:0]  i_s_axis_tuser  = '0;  // op[1:0]
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [39:0] o_m_axis_tdata;        // accepted[0], life_state[3:1], reply_code[6:4],
                                        // local_seq_out[22:7], remote_seq_out[38:23]

    // shadow copy of the connection state
    logic [2:0]  conn_state      = clfsm_pkg::ST_CLOSED;
    logic [15:0] conn_local_seq  = '0;
    logic [15:0] conn_remote_seq = '0;

    clfsm_pkg::t_result due_status[$];
    t_row               script [NUM_DIRECTED];
    bit                 row_typed  = 1'b0;
    clfsm_pkg::t_result row_want   = '0;
    int                 n_issued   = 0;
    int                 n_accepted = 0;
    int                 n_fail     = 0;
    int                 idle_run   = 0;
    int                 in_gap     = 0;
    int                 out_stall  = 0;
    bit                 calm       = 1'b0;

    connection_lifecycle_fsm_core u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    // clock and reset
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    function automatic clfsm_pkg::t_result status_of(logic acc, logic [2:0] st,
                                                     logic [2:0] rep, logic [15:0] loc,
                                                     logic [15:0] rem);
        clfsm_pkg::t_result r;
        r.accepted       = acc;
        r.life_state     = st;
        r.reply_code     = rep;
        r.local_seq_out  = loc;
        r.remote_seq_out = rem;
        return r;
    endfunction

    // next state and status word for one input word
    function automatic clfsm_pkg::t_result step_connection(logic [1:0] op, logic [2:0] cmd,
                                                           logic [15:0] peer);
        clfsm_pkg::t_result r;
        r = '0;
        case (op)
            clfsm_pkg::OP_SEND: begin
                if (cmd == clfsm_pkg::C_SYN)
                    conn_local_seq = clfsm_pkg::SYN_SEQ_BASE;
                if (conn_state == clfsm_pkg::ST_CLOSED && cmd == clfsm_pkg::C_HELO) begin
                    conn_state = clfsm_pkg::ST_LISTEN;
                    r.accepted = 1'b1;
                end else if (conn_state == clfsm_pkg::ST_LISTEN
                             && cmd == clfsm_pkg::C_SYN) begin
                    conn_state = clfsm_pkg::ST_SYN_SENT;
                    r.accepted = 1'b1;
                end else if (conn_state == clfsm_pkg::ST_SYN_RCVD
                             && cmd == clfsm_pkg::C_SYN_ACK) begin
                    conn_state = clfsm_pkg::ST_ESTABLISHED;
                    r.accepted = 1'b1;
                end else if (conn_state == clfsm_pkg::ST_ESTABLISHED
                             && cmd == clfsm_pkg::C_CLOSE) begin
                    conn_state = clfsm_pkg::ST_CLOSE_WAIT;
                    r.accepted = 1'b1;
                end
            end
            clfsm_pkg::OP_RECV: begin
                if (cmd <= clfsm_pkg::C_CLOSE) begin
                    if (conn_state == clfsm_pkg::ST_CLOSED && cmd == clfsm_pkg::C_HELO) begin
                        conn_state   = clfsm_pkg::ST_LISTEN;
                        r.reply_code = clfsm_pkg::R_SYN;
                        r.accepted   = 1'b1;
                    end else if (conn_state == clfsm_pkg::ST_LISTEN
                                 && cmd == clfsm_pkg::C_SYN) begin
                        conn_state   = clfsm_pkg::ST_SYN_RCVD;
                        r.reply_code = clfsm_pkg::R_SYN_ACK;
                        r.accepted   = 1'b1;
                    end else if ((conn_state == clfsm_pkg::ST_SYN_SENT
                                  || conn_state == clfsm_pkg::ST_SYN_RCVD)
                                 && cmd == clfsm_pkg::C_SYN_ACK) begin
                        conn_state = clfsm_pkg::ST_ESTABLISHED;
                        r.accepted = 1'b1;
                    end else if (conn_state == clfsm_pkg::ST_SYN_RCVD) begin
                        // half-open side keeps answering with syn-ack
                        r.reply_code = clfsm_pkg::R_SYN_ACK;
                    end else if (conn_state == clfsm_pkg::ST_ESTABLISHED
                                 && cmd == clfsm_pkg::C_DATA) begin
                        r.reply_code = clfsm_pkg::R_DATA_ACK;
                    end else if (conn_state == clfsm_pkg::ST_ESTABLISHED
                                 && cmd == clfsm_pkg::C_CLOSE) begin
                        conn_state   = clfsm_pkg::ST_CLOSED;
                        r.reply_code = clfsm_pkg::R_CLOSE_ACK;
                        r.accepted   = 1'b1;
                    end else if (conn_state == clfsm_pkg::ST_CLOSE_WAIT
                                 && cmd == clfsm_pkg::C_CLOSE) begin
                        conn_state = clfsm_pkg::ST_CLOSED;
                        r.accepted = 1'b1;
                    end
                    // any received syn reloads both sequence numbers
                    if (cmd == clfsm_pkg::C_SYN) begin
                        conn_remote_seq = peer;
                        conn_local_seq  = peer + clfsm_pkg::SYN_SEQ_BASE;
                    end
                end
            end
            clfsm_pkg::OP_CLOSE: conn_state = clfsm_pkg::ST_CLOSED;
            default: ;
        endcase
        r.life_state     = conn_state;
        r.local_seq_out  = conn_local_seq;
        r.remote_seq_out = conn_remote_seq;
        // take shows the old value, then counts up
        if (op == clfsm_pkg::OP_TAKE)
            conn_local_seq = conn_local_seq + 16'd1;
        return r;
    endfunction

    function automatic int pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        else if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    // mostly handshake-advancing words, with noise on top
    task automatic pick_word(output logic [1:0] op, output logic [2:0] cmd,
                             output logic [15:0] peer);
        int unsigned roll;
        roll = $urandom_range(0, 99);
        peer = 16'($urandom());
        if ($urandom_range(0, 7) == 0)
            peer = 16'hFEF0 + 16'($urandom_range(0, 15));
        op  = $urandom_range(0, 1) ? clfsm_pkg::OP_SEND : clfsm_pkg::OP_RECV;
        cmd = 3'($urandom_range(0, 7));
        if (roll < 70) begin
            case (conn_state)
                clfsm_pkg::ST_CLOSED: cmd = clfsm_pkg::C_HELO;
                clfsm_pkg::ST_LISTEN: cmd = clfsm_pkg::C_SYN;
                clfsm_pkg::ST_SYN_RCVD: begin
                    if ($urandom_range(0, 3) != 0)
                        cmd = clfsm_pkg::C_SYN_ACK;
                end
                clfsm_pkg::ST_SYN_SENT: begin
                    op  = clfsm_pkg::OP_RECV;
                    cmd = clfsm_pkg::C_SYN_ACK;
                end
                clfsm_pkg::ST_ESTABLISHED: begin
                    case ($urandom_range(0, 3))
                        0, 1: begin
                            op  = clfsm_pkg::OP_RECV;
                            cmd = clfsm_pkg::C_DATA;
                        end
                        2: cmd = clfsm_pkg::C_CLOSE;
                        default: op = clfsm_pkg::OP_TAKE;
                    endcase
                end
                clfsm_pkg::ST_CLOSE_WAIT: begin
                    op  = clfsm_pkg::OP_RECV;
                    cmd = clfsm_pkg::C_CLOSE;
                end
                default: cmd = clfsm_pkg::C_HELO;
            endcase
        end else if (roll < 82) begin
            op = clfsm_pkg::OP_TAKE;
        end else if (roll < 86) begin
            op = clfsm_pkg::OP_CLOSE;
        end else begin
            op = 2'($urandom_range(0, 3));
        end
    endtask

    task automatic compare_field(string name, logic [15:0] want, logic [15:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            n_fail++;
        end
    endtask

    // directed words: full handshakes both ways, replies, wraps, odd commands
    initial begin
        script = '{
            '{clfsm_pkg::OP_TAKE,  clfsm_pkg::C_HELO,     16'h0000, 1'b1,
              status_of(1'b0, clfsm_pkg::ST_CLOSED, clfsm_pkg::R_NONE,
                        16'h0000, 16'h0000)},
            '{clfsm_pkg::OP_RECV,  C_OTHER_HI,            16'hFFFF, 1'b1,
              status_of(1'b0, clfsm_pkg::ST_CLOSED, clfsm_pkg::R_NONE,
                        16'h0001, 16'h0000)},
            '{clfsm_pkg::OP_SEND,  C_OTHER_LO,            16'h0000, 1'b0, '0},
            '{clfsm_pkg::OP_SEND,  clfsm_pkg::C_HELO,     16'h0000, 1'b0, '0},
            '{clfsm_pkg::OP_SEND,  clfsm_pkg::C_SYN,      16'hFFFF, 1'b1,
              status_of(1'b1, clfsm_pkg::ST_SYN_SENT, clfsm_pkg::R_NONE,
                        16'h0100, 16'h0000)},
            '{clfsm_pkg::OP_RECV,  clfsm_pkg::C_SYN_ACK,  16'h0000, 1'b0, '0},
            '{clfsm_pkg::OP_RECV,  clfsm_pkg::C_DATA,     16'h1234, 1'b0, '0},
            '{clfsm_pkg::OP_SEND,  clfsm_pkg::C_DATA_ACK, 16'h0000, 1'b0, '0},
            '{clfsm_pkg::OP_SEND,  clfsm_pkg::C_CLOSE,    16'h0000, 1'b0, '0},
            '{clfsm_pkg::OP_RECV,  clfsm_pkg::C_CLOSE,    16'h0000, 1'b0, '0},
            '{clfsm_pkg::OP_RECV,  clfsm_pkg::C_HELO,     16'h0000, 1'b0, '0},
            '{clfsm_pkg::OP_RECV,  clfsm_pkg::C_SYN,      16'hFFFF, 1'b1,
              status_of(1'b1, clfsm_pkg::ST_SYN_RCVD, clfsm_pkg::R_SYN_ACK,
                        16'h00FF, 16'hFFFF)},
            '{clfsm_pkg::OP_RECV,  clfsm_pkg::C_HELO,     16'h0000, 1'b0, '0},
            '{clfsm_pkg::OP_RECV,  clfsm_pkg::C_DATA_ACK, 16'h0000, 1'b0, '0},
            '{clfsm_pkg::OP_RECV,  clfsm_pkg::C_SYN,      16'h0000, 1'b0, '0},
            '{clfsm_pkg::OP_RECV,  C_OTHER_LO,            16'h0000, 1'b0, '0},
            '{clfsm_pkg::OP_RECV,  clfsm_pkg::C_CLOSE,    16'h0000, 1'b0, '0},
            '{clfsm_pkg::OP_SEND,  clfsm_pkg::C_SYN_ACK,  16'h0000, 1'b0, '0},
            '{clfsm_pkg::OP_RECV,  clfsm_pkg::C_CLOSE,    16'h0000, 1'b0, '0},
            '{clfsm_pkg::OP_SEND,  clfsm_pkg::C_SYN,      16'h0000, 1'b1,
              status_of(1'b0, clfsm_pkg::ST_CLOSED, clfsm_pkg::R_NONE,
                        16'h0100, 16'h0000)},
            '{clfsm_pkg::OP_RECV,  clfsm_pkg::C_HELO,     16'h0000, 1'b0, '0},
            '{clfsm_pkg::OP_RECV,  clfsm_pkg::C_SYN,      16'hFEFF, 1'b0, '0},
            '{clfsm_pkg::OP_TAKE,  C_OTHER_HI,            16'hFFFF, 1'b1,
              status_of(1'b0, clfsm_pkg::ST_SYN_RCVD, clfsm_pkg::R_NONE,
                        16'hFFFF, 16'hFEFF)},
            '{clfsm_pkg::OP_CLOSE, clfsm_pkg::C_SYN,      16'h0000, 1'b1,
              status_of(1'b0, clfsm_pkg::ST_CLOSED, clfsm_pkg::R_NONE,
                        16'h0000, 16'hFEFF)},
            '{clfsm_pkg::OP_RECV,  clfsm_pkg::C_SYN,      16'h5555, 1'b0, '0}
        };
    end

    // both stream sides, prediction and checking in one place
    always @(posedge i_clk) begin : stream_io
        clfsm_pkg::t_result want_r;
        clfsm_pkg::t_result got;
        logic [1:0]         nxt_op;
        logic [2:0]         nxt_cmd;
        logic [15:0]        nxt_peer;
        bit                 in_fire;
        bit                 out_fire;
        if (i_rst_n) begin
            in_fire  = i_s_axis_tvalid && o_s_axis_tready;
            out_fire = o_m_axis_tvalid && i_m_axis_tready;

            // input word taken: predict its status word
            if (in_fire) begin
                want_r = step_connection(i_s_axis_tuser, i_s_axis_tdata[2:0],
                                         i_s_axis_tdata[18:3]);
                if (row_typed)
                    want_r = row_want;
                due_status.push_back(want_r);
                n_accepted++;
            end

            // status word out: compare with the oldest prediction
            if (out_fire) begin
                if (due_status.size() == 0) begin
                    $error("status word with nothing expected: %0h", o_m_axis_tdata);
                    n_fail++;
                end else begin
                    want_r = due_status.pop_front();
                    got    = clfsm_pkg::t_result'(o_m_axis_tdata[38:0]);
                    compare_field("accepted", 16'(want_r.accepted), 16'(got.accepted));
                    compare_field("life_state", 16'(want_r.life_state), 16'(got.life_state));
                    compare_field("reply_code", 16'(want_r.reply_code), 16'(got.reply_code));
                    compare_field("local_seq_out", want_r.local_seq_out, got.local_seq_out);
                    compare_field("remote_seq_out", want_r.remote_seq_out,
                                  got.remote_seq_out);
                end
            end

            idle_run = (in_fire || out_fire) ? 0 : idle_run + 1;
            if ($urandom_range(0, 255) == 0)
                calm = !calm;

            // next input word, after an optional gap
            if (in_fire || !i_s_axis_tvalid) begin
                if (in_gap > 0) begin
                    in_gap--;
                    i_s_axis_tvalid <= 1'b0;
                end else if (n_issued < TOTAL_WORDS) begin
                    row_typed = 1'b0;
                    if (n_issued < NUM_DIRECTED) begin
                        nxt_op    = script[n_issued].op;
                        nxt_cmd   = script[n_issued].cmd;
                        nxt_peer  = script[n_issued].peer;
                        row_typed = script[n_issued].typed;
                        row_want  = script[n_issued].want;
                    end else begin
                        pick_word(nxt_op, nxt_cmd, nxt_peer);
                    end
                    i_s_axis_tvalid <= 1'b1;
                    i_s_axis_tdata  <= {5'd0, nxt_peer, nxt_cmd};
                    i_s_axis_tuser  <= nxt_op;
                    n_issued++;
                    in_gap = calm ? 0 : pick_gap();
                end else begin
                    i_s_axis_tvalid <= 1'b0;
                end
            end

            // output backpressure
            if (out_stall > 0) begin
                out_stall--;
                i_m_axis_tready <= 1'b0;
            end else begin
                i_m_axis_tready <= 1'b1;
                if (!calm && $urandom_range(0, 3) == 0)
                    out_stall = pick_gap();
            end
        end
    end

    // watchdog on cycles without any word moving
    initial begin
        while (idle_run < WATCHDOG_LIMIT)
            @(posedge i_clk);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // end of run
    initial begin
        @(posedge i_clk);
        while (!(n_accepted == TOTAL_WORDS && due_status.size() == 0))
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (n_fail == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
